@@ rtl/tcrm_pkg.sv @@
// shared types, codes and constants of the throttled can receive mailbox
`default_nettype none

package tcrm_pkg;

	localparam int SLOTS_DEF = 16;

	// stream word layouts
	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 136;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TUSER_W = 2;
	localparam int OUT_ACC_BIT = 0;
	localparam int OUT_ID_LO   = 1;
	localparam int OUT_ID_HI   = 11;

	// item kinds on the output stream
	localparam logic [1:0] KIND_ACK    = 2'd0;
	localparam logic [1:0] KIND_FRAME  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// request kinds on the input stream
	localparam logic REQ_FRAME = 1'b0;
	localparam logic REQ_POLL  = 1'b1;

	// register map, word index
	localparam int         APB_AW          = 4;
	localparam logic [1:0] REG_ID_BASE     = 2'd0;
	localparam logic [1:0] REG_ID_COUNT    = 2'd1;
	localparam logic [1:0] REG_THROTTLE_MS = 2'd2;
	localparam logic [1:0] REG_SILENCE_MS  = 2'd3;

	localparam logic [10:0] ID_BASE_RST     = 11'd508;
	localparam logic [4:0]  ID_COUNT_RST    = 5'd12;
	localparam logic [15:0] THROTTLE_MS_RST = 16'd10;
	localparam logic [15:0] SILENCE_MS_RST  = 16'd1000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FRAME_RD,
		ST_FRAME_CHK,
		ST_POLL,
		ST_DRAIN_RD,
		ST_DRAIN_OUT,
		ST_STATUS
	} state_t;

	typedef struct packed {
		logic capture;
		logic ack_emit;
		logic poll_upd;
		logic scan_clr;
		logic scan_inc;
		logic drain_rd;
		logic drain_emit;
		logic status_emit;
	} cmd_t;

	typedef struct packed {
		logic pending_nz;
		logic cur_valid;
		logic scan_last;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        accepted;
		logic [10:0] id;
		logic [3:0]  len;
		logic [63:0] data;
		logic        link;
		logic [31:0] total;
		logic [15:0] missed;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [10:0] id;
		logic [3:0]  len;
		logic [63:0] data;
	} slot_t;

endpackage

`default_nettype wire

@@ rtl/tcrm_ctrl.sv @@
// sequencer for frame handling, poll decision and mailbox drain
`default_nettype none

module tcrm_ctrl import tcrm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [IN_TUSER_W-1:0] in_kind,
	output logic                       in_ready,
	input  wire sts_t                  sts,
	output cmd_t                       cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (in_kind == REQ_POLL) ? ST_POLL : ST_FRAME_RD;
				end
			end
			ST_FRAME_RD: state_nxt = ST_FRAME_CHK;
			ST_FRAME_CHK: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_POLL: state_nxt = sts.pending_nz ? ST_DRAIN_RD : ST_STATUS;
			ST_DRAIN_RD: begin
				if (sts.cur_valid) begin
					state_nxt = ST_DRAIN_OUT;
				end else if (sts.scan_last) begin
					state_nxt = ST_STATUS;
				end
			end
			ST_DRAIN_OUT: begin
				if (sts.out_free) begin
					state_nxt = sts.scan_last ? ST_STATUS : ST_DRAIN_RD;
				end
			end
			ST_STATUS: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_FRAME_RD: ;
			ST_FRAME_CHK: cmd.ack_emit = sts.out_free;
			ST_POLL: begin
				cmd.poll_upd = 1'b1;
				cmd.scan_clr = 1'b1;
			end
			ST_DRAIN_RD: begin
				cmd.drain_rd = sts.cur_valid;
				cmd.scan_inc = !sts.cur_valid && !sts.scan_last;
			end
			ST_DRAIN_OUT: begin
				cmd.drain_emit = sts.out_free;
				cmd.scan_inc   = sts.out_free && !sts.scan_last;
			end
			ST_STATUS: cmd.status_emit = sts.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/tcrm_dp.sv @@
// mailbox datapath: slot memories, throttle and silence timing, counters, output register
`default_nettype none

module tcrm_dp import tcrm_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cmd_t                   cmd,
	output sts_t                        sts,
	input  wire logic [10:0]            id_base,
	input  wire logic [4:0]             id_count,
	input  wire logic [15:0]            throttle_ms,
	input  wire logic [15:0]            silence_ms,
	input  wire logic [IN_TDATA_W-1:0]  in_data,
	input  wire logic                   out_ready,
	output logic                        out_valid,
	output logic [OUT_TDATA_W-1:0]      out_data,
	output logic [OUT_TUSER_W-1:0]      out_kind,
	output logic                        out_last
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// captured request
	logic [10:0] fid_q;
	logic [3:0]  flen_q;
	logic [63:0] fdata_q;
	logic [31:0] now_q;

	// mailbox storage
	slot_t       slot_mem [SLOTS];
	logic [31:0] time_mem [SLOTS];
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] time_set_q;

	// status and counters
	logic [7:0]  pending_q;
	logic [31:0] total_q;
	logic [15:0] missed_q;
	logic [31:0] last_poll_q;
	logic        silent_q;
	logic [IW-1:0] scan_q;

	logic          hit_s1;
	logic [IW-1:0] idx_s1;
	logic [31:0]   time_rd_s1;
	logic          time_set_s1;
	slot_t         slot_rd_s1;

	out_item_t out_q;
	logic      out_valid_q;

	logic [11:0]   off_w;
	logic [10:0]   cnt_w;
	logic          hit_w;
	logic [IW-1:0] idx_w;
	logic [31:0]   since_w;
	logic          pass_w;
	logic [31:0]   quiet_w;
	logic          load_w;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			fid_q   <= in_data[10:0];
			flen_q  <= in_data[14:11];
			fdata_q <= in_data[78:15];
			now_q   <= in_data[110:79];
		end
	end

	// window test against the identifier range, clipped to the slot count
	always_comb begin
		off_w = {1'b0, fid_q} - {1'b0, id_base};
		cnt_w = (11'(id_count) > 11'(SLOTS)) ? 11'(SLOTS) : 11'(id_count);
		hit_w = !off_w[11] && (off_w[10:0] < cnt_w);
		idx_w = off_w[IW-1:0];
	end

	always_ff @(posedge clk) begin
		hit_s1      <= hit_w;
		idx_s1      <= idx_w;
		time_rd_s1  <= time_mem[idx_w];
		time_set_s1 <= time_set_q[idx_w];
		if (cmd.drain_rd) begin
			slot_rd_s1 <= slot_mem[scan_q];
		end
	end

	// a slot never stored compares against time zero
	assign since_w = now_q - (time_set_s1 ? time_rd_s1 : 32'd0);
	assign pass_w  = hit_s1 && (since_w > {16'd0, throttle_ms});
	assign quiet_w = now_q - last_poll_q;

	always_ff @(posedge clk) begin
		if (cmd.ack_emit && pass_w) begin
			time_mem[idx_s1] <= now_q;
			slot_mem[idx_s1] <= '{id: fid_q, len: flen_q, data: fdata_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			time_set_q <= '0;
		end else begin
			if (cmd.ack_emit && pass_w) begin
				valid_q[idx_s1]    <= 1'b1;
				time_set_q[idx_s1] <= 1'b1;
			end
			if (cmd.drain_emit) begin
				valid_q[scan_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			total_q     <= '0;
			missed_q    <= '0;
			last_poll_q <= '0;
			silent_q    <= 1'b0;
		end else if (cmd.ack_emit && pass_w) begin
			if (pending_q != 8'hFF) begin
				pending_q <= pending_q + 8'd1;
			end
		end else if (cmd.poll_upd) begin
			if (pending_q != 8'd0) begin
				total_q     <= total_q + {24'd0, pending_q};
				missed_q    <= '0;
				silent_q    <= 1'b0;
				pending_q   <= '0;
				last_poll_q <= now_q;
			end else if (quiet_w > {16'd0, silence_ms}) begin
				silent_q    <= 1'b1;
				last_poll_q <= now_q;
				if (missed_q != 16'hFFFF) begin
					missed_q <= missed_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.scan_clr) begin
			scan_q <= '0;
		end else if (cmd.scan_inc) begin
			scan_q <= scan_q + IW'(1);
		end
	end

	assign load_w = cmd.ack_emit || cmd.drain_emit || cmd.status_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_w) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_w) begin
			out_q.kind     <= cmd.ack_emit ? KIND_ACK :
				(cmd.drain_emit ? KIND_FRAME : KIND_STATUS);
			out_q.accepted <= cmd.ack_emit && pass_w;
			out_q.id       <= cmd.drain_emit ? slot_rd_s1.id : 11'd0;
			out_q.len      <= cmd.drain_emit ? slot_rd_s1.len : 4'd0;
			out_q.data     <= cmd.drain_emit ? slot_rd_s1.data : 64'd0;
			out_q.link     <= silent_q;
			out_q.total    <= total_q;
			out_q.missed   <= missed_q;
			out_q.last     <= !cmd.drain_emit;
		end
	end

	assign sts.pending_nz = (pending_q != 8'd0);
	assign sts.cur_valid  = valid_q[scan_q];
	assign sts.scan_last  = (scan_q == IW'(SLOTS - 1));
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_kind  = out_q.kind;
	assign out_last  = out_q.last;
	assign out_data  = {7'd0, out_q.missed, out_q.total, out_q.link, out_q.data,
		out_q.len, out_q.id, out_q.accepted};

endmodule

`default_nettype wire

@@ rtl/throttled_can_rx_mailbox_unit.sv @@
// top level: register port, sequencer and mailbox datapath
`default_nettype none

// Receive mailbox with one slot per CAN identifier in the window id_base to
// id_base+id_count-1, with id_count clipped to SLOTS, and a per-slot rate
// limit of throttle_ms. A frame word (tuser 0) passes through a slot read and
// a check step and returns one acknowledge word whose accepted bit tells
// whether it was stored; the slot time memory read and the compare that follows
// set that bit. A poll word (tuser 1) with nothing pending returns only a status
// word; with frames pending the drain steps through all SLOTS slots of the slot
// memory one entry at a time and returns each stored frame in identifier order,
// then a status word marked by tlast.
// A new input word is taken only after the previous one has produced all its
// result words into the output register. Registers are written over the APB
// port at byte addresses 0, 4, 8 and 12 and should be changed only when idle.

module throttled_can_rx_mailbox_unit import tcrm_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// apb register port
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [APB_AW-1:0]      paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// request stream
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// frame_id, frame_len, frame_data, now_ms, zero fill
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// req_type
	input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
	// result stream
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// accepted, out_id, out_len, out_data, link_status, message_total,
	// missed_polls, zero fill
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	// item_kind
	output logic [OUT_TUSER_W-1:0]      m_axis_tuser,
	output logic                        m_axis_tlast
);

	logic [10:0] id_base_q;
	logic [4:0]  id_count_q;
	logic [15:0] throttle_q;
	logic [15:0] silence_q;
	logic        wr_w;
	logic [1:0]  reg_sel_w;
	cmd_t        cmd;
	sts_t        sts;

	assign pready    = 1'b1;
	assign wr_w      = psel && penable && pwrite && pready;
	assign reg_sel_w = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q  <= ID_BASE_RST;
			id_count_q <= ID_COUNT_RST;
			throttle_q <= THROTTLE_MS_RST;
			silence_q  <= SILENCE_MS_RST;
		end else if (wr_w) begin
			unique case (reg_sel_w)
				REG_ID_BASE:     id_base_q  <= pwdata[10:0];
				REG_ID_COUNT:    id_count_q <= pwdata[4:0];
				REG_THROTTLE_MS: throttle_q <= pwdata[15:0];
				REG_SILENCE_MS:  silence_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel_w)
			REG_ID_BASE:     prdata = {21'd0, id_base_q};
			REG_ID_COUNT:    prdata = {27'd0, id_count_q};
			REG_THROTTLE_MS: prdata = {16'd0, throttle_q};
			REG_SILENCE_MS:  prdata = {16'd0, silence_q};
			default:         prdata = '0;
		endcase
	end

	tcrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tcrm_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.id_base     (id_base_q),
		.id_count    (id_count_q),
		.throttle_ms (throttle_q),
		.silence_ms  (silence_q),
		.in_data     (s_axis_tdata),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_data    (m_axis_tdata),
		.out_kind    (m_axis_tuser),
		.out_last    (m_axis_tlast)
	);

endmodule

`default_nettype wire

@@ rtl/tcrm_checker.sv @@
// port-level checks of the result stream, bound to the top level
`default_nettype none

module tcrm_port_checker import tcrm_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic [OUT_TUSER_W-1:0] m_axis_tuser,
	input wire logic                   m_axis_tlast
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("result word changed while stalled");

	// an acknowledge and a status word close their request, a drained frame never does
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_FRAME)))
		else $error("tlast wrong for item kind");

	// only an acknowledge may carry the accepted flag
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != KIND_ACK) |-> !m_axis_tdata[OUT_ACC_BIT])
		else $error("accepted set outside an acknowledge");

	// acknowledge and status words carry no identifier
	a_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != KIND_FRAME) |->
			(m_axis_tdata[OUT_ID_HI:OUT_ID_LO] == '0))
		else $error("identifier set outside a drained frame");

endmodule

bind throttled_can_rx_mailbox_unit tcrm_port_checker u_tcrm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
